FILE: rtl/ash_pkg.sv
// ============================================================================
// ash_pkg
// Shared types and constants of the sampled-address histogram.
// ============================================================================
`default_nettype none

package ash_pkg;

    localparam int ADDR_W  = 64;
    localparam int COUNT_W = 32;
    localparam int SUM_W   = 48;
    localparam int WORD_W  = ADDR_W + COUNT_W;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_NEW     = 3'd1,
        ST_IGNORED = 3'd2,
        ST_FULL    = 3'd3,
        ST_READ    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_SEARCH,
        S_READ
    } ctrl_state_t;

    typedef struct packed {
        logic                mode;
        logic [ADDR_W-1:0]   sample_address;
        logic [COUNT_W-1:0]  add_count;
        logic [5:0]          read_slot;
    } in_item_t;

    typedef struct packed {
        status_t             status;
        logic [5:0]          slot;
        logic                slot_valid;
        logic [ADDR_W-1:0]   slot_address;
        logic [COUNT_W-1:0]  slot_count;
        logic [6:0]          used_entries;
        logic [SUM_W-1:0]    total_samples;
    } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/ash_table_ram.sv
// ============================================================================
// ash_table_ram
// Single-port-write, single-port-read table memory with registered read data.
// ============================================================================
`default_nettype none

module ash_table_ram #(
    parameter int DEPTH  = 64,
    parameter int AW     = 6,
    parameter int DW     = 96
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/ash_ctrl.sv
// ============================================================================
// ash_ctrl
// Sequencer that searches the table, updates or appends entries, reads slots, and
// keeps the running entry and sample totals.
// ============================================================================
`default_nettype none

module ash_ctrl #(
    parameter int TABLE_ENTRIES = 64,
    parameter int IDX_W         = 6,
    parameter int CNT_W         = 7
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     req_valid,
    output logic                          req_ready,
    input  wire ash_pkg::in_item_t        req,
    output logic                          res_valid,
    input  wire logic                     res_ready,
    output ash_pkg::out_item_t            res,
    output logic                          mem_we,
    output logic [IDX_W-1:0]              mem_waddr,
    output logic [ash_pkg::WORD_W-1:0]    mem_wdata,
    output logic [IDX_W-1:0]              mem_raddr,
    input  wire logic [ash_pkg::WORD_W-1:0] mem_rdata
);

    import ash_pkg::*;

    ctrl_state_t         state_reg, state_next;
    in_item_t            item_reg, item_next;
    logic [IDX_W-1:0]    scan_reg, scan_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                done_reg, done_next;
    status_t             status_reg, status_next;
    logic [5:0]          slot_reg, slot_next;
    logic                valid_reg, valid_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    logic [ADDR_W-1:0]   rd_addr;
    logic [COUNT_W-1:0]  rd_count;
    logic [COUNT_W:0]    cnt_add;
    logic [COUNT_W-1:0]  cnt_sat;
    logic [SUM_W:0]      sum_add;
    logic [SUM_W-1:0]    sum_sat;
    logic [31:0]         scan_ext;
    logic [31:0]         total_ext;
    logic [31:0]         rslot_ext;
    logic                is_full;
    logic                scan_last;

    assign rd_addr   = mem_rdata[WORD_W-1:COUNT_W];
    assign rd_count  = mem_rdata[COUNT_W-1:0];
    assign cnt_add   = {1'b0, rd_count} + {1'b0, item_reg.add_count};
    assign cnt_sat   = cnt_add[COUNT_W] ? '1 : cnt_add[COUNT_W-1:0];
    assign sum_add   = {1'b0, sum_reg} + (SUM_W+1)'(item_reg.add_count);
    assign sum_sat   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    assign scan_ext  = 32'(scan_reg);
    assign total_ext = 32'(total_reg);
    assign rslot_ext = 32'(item_reg.read_slot);
    assign is_full   = (total_reg == CNT_W'(TABLE_ENTRIES));
    assign scan_last = ((CNT_W'(scan_reg) + CNT_W'(1)) == total_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            sum_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            sum_reg   <= sum_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        scan_reg   <= scan_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        valid_reg  <= valid_next;
        addr_reg   <= addr_next;
        count_reg  <= count_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        scan_next   = scan_reg;
        total_next  = total_reg;
        sum_next    = sum_reg;
        done_next   = done_reg;
        status_next = status_reg;
        slot_next   = slot_reg;
        valid_next  = valid_reg;
        addr_next   = addr_reg;
        count_next  = count_reg;
        req_ready   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = total_reg[IDX_W-1:0];
        mem_wdata   = {item_reg.sample_address, item_reg.add_count};
        mem_raddr   = scan_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (done_reg)
                begin
                    if (res_ready)
                    begin
                        done_next = 1'b0;
                    end
                end
                else
                begin
                    req_ready = 1'b1;
                    if (req_valid)
                    begin
                        item_next  = req;
                        state_next = S_START;
                    end
                end
            end

            S_START:
            begin
                status_next = ST_IGNORED;
                slot_next   = '0;
                valid_next  = 1'b0;
                addr_next   = '0;
                count_next  = '0;
                if (item_reg.mode == MODE_READ)
                begin
                    status_next = ST_READ;
                    slot_next   = item_reg.read_slot;
                    mem_raddr   = IDX_W'(item_reg.read_slot);
                    if (rslot_ext < total_ext)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (item_reg.sample_address == '0)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (total_reg == '0)
                begin
                    mem_we      = 1'b1;
                    total_next  = total_reg + CNT_W'(1);
                    sum_next    = sum_sat;
                    status_next = ST_NEW;
                    slot_next   = total_ext[5:0];
                    valid_next  = 1'b1;
                    addr_next   = item_reg.sample_address;
                    count_next  = item_reg.add_count;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    mem_raddr  = '0;
                    scan_next  = '0;
                    state_next = S_SEARCH;
                end
            end

            S_SEARCH:
            begin
                if (rd_addr == item_reg.sample_address)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = scan_reg;
                    mem_wdata   = {rd_addr, cnt_sat};
                    sum_next    = sum_sat;
                    status_next = ST_ADDED;
                    slot_next   = scan_ext[5:0];
                    valid_next  = 1'b1;
                    addr_next   = rd_addr;
                    count_next  = cnt_sat;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (!scan_last)
                begin
                    scan_next = scan_reg + IDX_W'(1);
                    mem_raddr = scan_reg + IDX_W'(1);
                end
                else if (is_full)
                begin
                    status_next = ST_FULL;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    mem_we      = 1'b1;
                    total_next  = total_reg + CNT_W'(1);
                    sum_next    = sum_sat;
                    status_next = ST_NEW;
                    slot_next   = total_ext[5:0];
                    valid_next  = 1'b1;
                    addr_next   = item_reg.sample_address;
                    count_next  = item_reg.add_count;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_READ:
            begin
                valid_next = 1'b1;
                addr_next  = rd_addr;
                count_next = rd_count;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_valid          = done_reg;
    assign res.status         = status_reg;
    assign res.slot           = slot_reg;
    assign res.slot_valid     = valid_reg;
    assign res.slot_address   = addr_reg;
    assign res.slot_count     = count_reg;
    assign res.used_entries   = total_ext[6:0];
    assign res.total_samples  = sum_reg;

    a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        total_ext <= 32'(TABLE_ENTRIES))
        else $error("entry total exceeds table size");

    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg != $past(total_reg)) |-> (total_reg == $past(total_reg) + CNT_W'(1)))
        else $error("entry total moved by more than one");

    a_sum_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg >= $past(sum_reg))
        else $error("sample sum decreased");

    a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_START || state_reg == S_SEARCH))
        else $error("table written outside an update");

    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !req_ready)
        else $error("new transaction taken while a result is pending");

endmodule

`default_nettype wire

FILE: rtl/address_sample_histogram.sv
// ============================================================================
// address_sample_histogram
// Bounded table of sampled code addresses with saturating per-address counts,
// kept in insertion order, plus running entry and sample totals.
// ============================================================================
//  Channel  Direction  Handshake              Payload
//  req      in         req_valid / req_ready  ash_pkg::in_item_t
//  rsp      out        rsp_valid / rsp_ready  ash_pkg::out_item_t
//
// The result is set in S_START for an ignored address, a read of an unused
// slot or the first entry, and in S_READ after S_START for a read of a used
// slot. An add scans one entry per cycle through the single memory read port,
// probing at most the table size of entries in S_SEARCH. The next transaction
// is taken once the result before it has moved into the output register.
// Reset clears the totals and control state; table contents need no clearing.
// The result sits in an output register, so a new transaction is taken while
// a result still waits on rsp_ready; the one after waits for that result.
// ============================================================================
`default_nettype none

module address_sample_histogram #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire ash_pkg::in_item_t  req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output ash_pkg::out_item_t      rsp
);

    import ash_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    logic               res_valid;
    logic               res_ready;
    out_item_t          res;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    logic [WORD_W-1:0]  mem_rdata;

    logic               rsp_valid_reg, rsp_valid_next;
    out_item_t          rsp_reg, rsp_next;

    ash_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W),
        .CNT_W         (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ash_table_ram #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDX_W),
        .DW    (WORD_W)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_ready)
        begin
            rsp_valid_next = res_valid;
            if (res_valid)
            begin
                rsp_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
